[rtl/dvtm_pkg.sv]
// Shared types and constants of the distance-vector routing table.
package dvtm_pkg;

  localparam int NODES    = 128;
  localparam int ADDR_W   = 7;
  localparam int NEXT_W   = 8;
  localparam int COST_W   = 24;
  localparam int CMD_W    = 2;
  localparam int ENTRY_W  = NEXT_W + COST_W;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_USED_W  = ENTRY_W + 2;

  localparam logic [COST_W-1:0] COST_INF = '1;
  localparam logic [NEXT_W-1:0] NO_ROUTE = NEXT_W'(NODES);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 2'd0,
    CMD_ADVERTISE = 2'd1,
    CMD_READ      = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOP,
    ST_EXEC
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] sender;
    logic [COST_W-1:0] link_cost;
    logic              sender_direct;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [NEXT_W-1:0] next;
    logic [COST_W-1:0] cost;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   wr_en;
    logic   self_hit;
    logic   changed;
    logic   round_unch;
    logic   round_nxt;
  } merge_res_t;

endpackage

[rtl/dvtm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dvtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/dvtm_merge.sv]
// Bellman-Ford merge, write and read decision for one table entry.
module dvtm_merge (
  input  dvtm_pkg::item_t                item,
  input  dvtm_pkg::entry_t               cur,
  input  logic                           self_v,
  input  logic [dvtm_pkg::ADDR_W-1:0]    node_id,
  input  logic                           round_r,
  output dvtm_pkg::merge_res_t           res
);
  import dvtm_pkg::*;

  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cand;
  logic              skip;

  always_comb begin
    sum  = {1'b0, item.cost} + {1'b0, item.link_cost};
    // saturate one below infinity
    cand = (sum >= {1'b0, COST_INF}) ? (COST_INF - COST_W'(1)) : sum[COST_W-1:0];
    skip = (item.dest == item.sender) || (item.dest == node_id) || (item.cost == COST_INF);

    res            = '0;
    res.entry      = cur;
    res.round_nxt  = round_r;

    case (item.command)
      CMD_WRITE: begin
        res.wr_en = 1'b1;
        if (item.cost == COST_INF) begin
          res.entry.next = NO_ROUTE;
          res.entry.cost = COST_INF;
        end else begin
          res.entry.next = {1'b0, item.dest};
          res.entry.cost = item.cost;
          res.self_hit   = 1'b1;
        end
      end
      CMD_ADVERTISE: begin
        if (!skip) begin
          if ((cur.cost == COST_INF) || (cand < cur.cost)) begin
            res.changed    = 1'b1;
            res.wr_en      = 1'b1;
            res.entry.next = {1'b0, item.sender};
            res.entry.cost = cand;
          end else if ((cand == cur.cost) && item.sender_direct) begin
            // tie: displace a hop whose own entry does not point at itself, or one above the sender
            if (!self_v) begin
              res.changed    = 1'b1;
              res.wr_en      = 1'b1;
              res.entry.next = {1'b0, item.sender};
            end else if (cur.next > {1'b0, item.sender}) begin
              res.wr_en      = 1'b1;
              res.entry.next = {1'b0, item.sender};
            end
          end
        end
        res.round_nxt = round_r | res.changed;
        if (item.last) begin
          res.round_unch = !res.round_nxt;
          res.round_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/distance_vector_table_merge_top.sv]
// Top level: routing table RAM, self-hop flag RAM, control FSM and result register.
// A request passes the dest read, the next hop flag read and the merge, whose result is
// registered; no new request is taken until then, and a result that is not taken holds
// the merge step.
// Reset (rst_n low, synchronous): all entries read as no route at infinite cost,
// round flag cleared, node_id 0, no result pending.
module distance_vector_table_merge_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,      // node_id
  input  logic        in_tvalid,
  output logic        in_tready,
  // dest[6:0], cost[30:7], sender[37:31], link_cost[61:38], sender_direct[62], zero[63]
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,      // command[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // entry_next[7:0], entry_cost[31:8], changed[32], round_unchanged[33], zero[39:34]
  output logic [39:0] out_tdata
);
  import dvtm_pkg::*;

  state_t                state_r, state_nxt;
  item_t                 item_r, in_item;
  logic [ADDR_W-1:0]     node_id_r;
  logic                  round_r;
  logic [NODES-1:0]      valid_r;
  logic                  out_valid_r;
  logic [OUT_USED_W-1:0] out_data_r;

  logic                  in_acc;
  logic                  go;
  logic                  hop_re;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [ADDR_W-1:0]     hop_addr;
  logic                  hop_self;
  entry_t                cur;
  logic                  self_v;
  merge_res_t            mres;

  assign in_item.command       = cmd_t'(in_tuser);
  assign in_item.dest          = in_tdata[6:0];
  assign in_item.cost          = in_tdata[30:7];
  assign in_item.sender        = in_tdata[37:31];
  assign in_item.link_cost     = in_tdata[61:38];
  assign in_item.sender_direct = in_tdata[62];
  assign in_item.last          = in_tlast;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_HOP;
      ST_HOP:  state_nxt = ST_EXEC;
      ST_EXEC: if (go)     state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready = 1'b0;
    hop_re    = 1'b0;
    go        = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_HOP:  hop_re    = 1'b1;
      ST_EXEC: go        = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign ram_re = in_acc;

  dvtm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (go && mres.wr_en),
    .waddr (item_r.dest),
    .wdata (mres.entry),
    .re    (ram_re),
    .raddr (in_item.dest),
    .rdata (ram_rdata)
  );

  // one bit per entry: its next hop is the entry itself
  dvtm_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_self_ram (
    .clk   (clk),
    .we    (go && mres.wr_en),
    .waddr (item_r.dest),
    .wdata (mres.self_hit),
    .re    (hop_re),
    .raddr (hop_addr),
    .rdata (hop_self)
  );

  // entries never written read as no route
  always_comb begin
    if (valid_r[item_r.dest]) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur.next = NO_ROUTE;
      cur.cost = COST_INF;
    end
  end

  assign hop_addr = cur.next[ADDR_W-1:0];
  assign self_v   = !cur.next[NEXT_W-1] && valid_r[hop_addr] && hop_self;

  dvtm_merge u_merge (
    .item    (item_r),
    .cur     (cur),
    .self_v  (self_v),
    .node_id (node_id_r),
    .round_r (round_r),
    .res     (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      node_id_r   <= '0;
      round_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        node_id_r <= cfg_data;
      end
      if (go) begin
        round_r     <= mres.round_nxt;
        out_valid_r <= 1'b1;
        if (mres.wr_en) begin
          valid_r[item_r.dest] <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (go) begin
      out_data_r <= {mres.round_unch, mres.changed, mres.entry.cost, mres.entry.next};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_data_r};

  // an accepted request always moves on to the next hop lookup
  a_accept_hop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_HOP))
    else $error("accepted request did not enter next hop lookup");

  // a changed entry always names the sender as next hop
  a_changed_hop: assert property (@(posedge clk) disable iff (!rst_n)
    (go && mres.changed) |-> (mres.entry.next == {1'b0, item_r.sender}))
    else $error("changed entry without sender as next hop");

  // a change in the round forbids reporting it unchanged
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[33]))
    else $error("changed and round_unchanged both set");

endmodule

[dv/distance_vector_table_merge_top_tb.sv]
// Self-checking testbench of the distance-vector routing table merge block.
module distance_vector_table_merge_top_tb;
  import dvtm_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [COST_W-1:0] COST_CEIL  = COST_INF - 24'd1;
  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 215;
  localparam int SETTLE_CYCLES    = 6;
  localparam int CYCLE_LIMIT      = 300000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] sender;
    logic [COST_W-1:0] link;
    logic              direct;
    logic              last;
  } req_t;

  typedef struct packed {
    logic [NEXT_W-1:0] next;
    logic [COST_W-1:0] cost;
    logic              changed;
    logic              round_unch;
  } report_t;

  typedef struct packed {
    req_t    r;
    logic    typed;
    report_t want;
  } dir_row_t;

  localparam report_t NO_ENTRY = '{NO_ROUTE, COST_INF, 1'b0, 1'b0};
  localparam report_t UNTYPED  = '0;
  localparam int NUM_DIRECTED  = 23;

  // node_id stays at its reset value 0 through these rows
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{CMD_READ, 7'd5, 24'd0, 7'd0, 24'd0, 1'b0, 1'b0}, 1'b1, NO_ENTRY},
    '{'{CMD_READ, 7'd127, COST_INF, 7'd127, COST_INF, 1'b1, 1'b1}, 1'b1, NO_ENTRY},
    '{'{CMD_UNUSED, 7'd0, 24'd9, 7'd3, 24'd1, 1'b1, 1'b1}, 1'b1, NO_ENTRY},
    '{'{CMD_WRITE, 7'd3, 24'd0, 7'd0, 24'd0, 1'b0, 1'b0}, 1'b1,
      '{8'd3, 24'd0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 7'd127, COST_CEIL, 7'd127, COST_INF, 1'b1, 1'b1}, 1'b1,
      '{8'd127, COST_CEIL, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 7'd127, COST_INF, 7'd0, 24'd0, 1'b0, 1'b0}, 1'b1, NO_ENTRY},
    // skipped: dest is own node, dest is sender, infinite cost
    '{'{CMD_ADVERTISE, 7'd0, 24'd5, 7'd9, 24'd1, 1'b0, 1'b0}, 1'b1, NO_ENTRY},
    '{'{CMD_ADVERTISE, 7'd9, 24'd5, 7'd9, 24'd1, 1'b0, 1'b0}, 1'b1, NO_ENTRY},
    '{'{CMD_ADVERTISE, 7'd10, COST_INF, 7'd9, 24'd1, 1'b0, 1'b0}, 1'b1, NO_ENTRY},
    '{'{CMD_ADVERTISE, 7'd10, 24'd4, 7'd9, 24'd6, 1'b0, 1'b0}, 1'b1,
      '{8'd9, 24'd10, 1'b1, 1'b0}},
    // equal cost, indirect neighbor, then direct neighbor
    '{'{CMD_ADVERTISE, 7'd10, 24'd5, 7'd8, 24'd5, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{CMD_ADVERTISE, 7'd10, 24'd5, 7'd8, 24'd5, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{CMD_WRITE, 7'd8, 24'd7, 7'd0, 24'd0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    // ties against a self-hop next hop: bigger sender, then smaller sender
    '{'{CMD_ADVERTISE, 7'd10, 24'd2, 7'd20, 24'd8, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{CMD_ADVERTISE, 7'd10, 24'd1, 7'd2, 24'd9, 1'b1, 1'b1}, 1'b0, UNTYPED},
    // saturating sum, then a round with no change
    '{'{CMD_ADVERTISE, 7'd11, COST_CEIL, 7'd4, COST_INF, 1'b0, 1'b1}, 1'b1,
      '{8'd4, COST_CEIL, 1'b1, 1'b0}},
    '{'{CMD_ADVERTISE, 7'd11, COST_CEIL, 7'd6, 24'd0, 1'b0, 1'b1}, 1'b1,
      '{8'd4, COST_CEIL, 1'b0, 1'b1}},
    '{'{CMD_ADVERTISE, 7'd11, 24'd0, 7'd0, 24'd0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{CMD_ADVERTISE, 7'd127, 24'd1, 7'd126, COST_CEIL, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{CMD_READ, 7'd11, 24'd0, 7'd0, 24'd0, 1'b0, 1'b1}, 1'b0, UNTYPED},
    '{'{CMD_WRITE, 7'd0, 24'd0, 7'd5, 24'd3, 1'b1, 1'b1}, 1'b1,
      '{8'd0, 24'd0, 1'b0, 1'b0}},
    '{'{CMD_ADVERTISE, 7'd0, 24'd0, 7'd1, 24'd0, 1'b1, 1'b1}, 1'b0, UNTYPED},
    '{'{CMD_ADVERTISE, 7'd5, 24'd0, 7'd3, 24'd0, 1'b1, 1'b1}, 1'b0, UNTYPED}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [6:0]        cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;
  logic [1:0]        in_tuser;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [39:0]       out_tdata;

  // predictor copy of the table
  logic [NEXT_W-1:0] tbl_next [NODES];
  logic [COST_W-1:0] tbl_cost [NODES];
  logic              tbl_round_dirty;
  logic [ADDR_W-1:0] tbl_node_id;

  report_t           report_q [$];
  report_t           owed_report;
  int                fail_cnt;
  int                cycle_cnt;
  int                burst_left;
  logic [15:0]       ready_pattern;
  int                pattern_pos;

  distance_vector_table_merge_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One merge step: updates the table copy and returns the entry report.
  function automatic report_t merge_table_step(input req_t r);
    report_t           rep;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cand;
    logic [NEXT_W-1:0] v;
    logic              v_self;
    rep = '0;
    if (r.cmd == CMD_WRITE) begin
      if (r.cost == COST_INF) begin
        tbl_next[r.dest] = NO_ROUTE;
        tbl_cost[r.dest] = COST_INF;
      end else begin
        tbl_next[r.dest] = {1'b0, r.dest};
        tbl_cost[r.dest] = r.cost;
      end
    end else if (r.cmd == CMD_ADVERTISE) begin
      if (r.dest != r.sender && r.dest != tbl_node_id && r.cost != COST_INF) begin
        sum  = {1'b0, r.cost} + {1'b0, r.link};
        cand = (sum >= {1'b0, COST_INF}) ? COST_CEIL : sum[COST_W-1:0];
        if (tbl_cost[r.dest] == COST_INF || cand < tbl_cost[r.dest]) begin
          rep.changed = 1'b1;
          tbl_next[r.dest] = {1'b0, r.sender};
          tbl_cost[r.dest] = cand;
        end else if (cand == tbl_cost[r.dest] && r.direct) begin
          v = tbl_next[r.dest];
          // a hop outside the table looks up as no route
          v_self = (v < NODES) ? (tbl_next[v[ADDR_W-1:0]] == v) : (v == NO_ROUTE);
          if (!v_self) begin
            rep.changed = 1'b1;
            tbl_next[r.dest] = {1'b0, r.sender};
          end else if (v > {1'b0, r.sender}) begin
            tbl_next[r.dest] = {1'b0, r.sender};
          end
        end
      end
      if (rep.changed) tbl_round_dirty = 1'b1;
      if (r.last) begin
        rep.round_unch  = !tbl_round_dirty;
        tbl_round_dirty = 1'b0;
      end
    end
    rep.next = tbl_next[r.dest];
    rep.cost = tbl_cost[r.dest];
    return rep;
  endfunction

  // Mostly a handful of nodes so that entries collide and ties occur.
  function automatic logic [ADDR_W-1:0] pick_node();
    if ($urandom_range(0, 99) < 80) return ADDR_W'($urandom_range(0, 7));
    return ADDR_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return COST_W'($urandom_range(0, 6));
    if (roll < 75) return COST_INF;
    if (roll < 85) return COST_INF - COST_W'($urandom_range(1, 3));
    return COST_W'($urandom);
  endfunction

  function automatic logic [COST_W-1:0] pick_link();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return COST_W'($urandom_range(0, 3));
    if (roll < 85) return COST_INF - COST_W'($urandom_range(0, 3));
    return COST_W'($urandom);
  endfunction

  task automatic send_request(input req_t r, input logic typed, input report_t want);
    int gap;
    report_t rep;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r.direct, r.link, r.sender, r.cost, r.dest};
    in_tuser  <= r.cmd;
    in_tlast  <= r.last;
    do @(posedge clk); while (!in_tready);
    rep = merge_table_step(r);
    report_q.insert(report_q.size(), typed ? want : rep);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_node_id(input logic [ADDR_W-1:0] id);
    cfg_valid <= 1'b1;
    cfg_data  <= id;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    tbl_node_id = id;
  endtask

  initial begin
    int phase, sent, len, k, roll;
    logic [ADDR_W-1:0] snd, id;
    req_t r;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    burst_left = 0;
    for (int i = 0; i < NODES; i++) begin
      tbl_next[i] = NO_ROUTE;
      tbl_cost[i] = COST_INF;
    end
    tbl_round_dirty = 1'b0;
    tbl_node_id     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_request(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    drain_results();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) id = 7'd127;
      else if (phase == 1) id = 7'd0;
      else id = pick_node();
      set_node_id(id);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          // one neighbor's round; now and then the closing mark is dropped
          snd = pick_node();
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++) begin
            r = '{CMD_ADVERTISE, pick_node(), pick_cost(), snd, pick_link(),
                  1'($urandom), 1'b0};
            r.last = (k == len - 1) && ($urandom_range(0, 9) != 0);
            send_request(r, 1'b0, UNTYPED);
          end
          sent += len;
        end else begin
          if (roll < 80)
            r = '{CMD_WRITE, pick_node(), pick_cost(), 7'($urandom), 24'($urandom),
                  1'($urandom), 1'($urandom)};
          else if (roll < 94)
            r = '{CMD_READ, pick_node(), 24'($urandom), 7'($urandom), 24'($urandom),
                  1'($urandom), 1'($urandom)};
          else
            r = '{2'($urandom), 7'($urandom), 24'($urandom), 7'($urandom),
                  24'($urandom), 1'($urandom), 1'($urandom)};
          send_request(r, 1'b0, UNTYPED);
          sent++;
        end
      end
      drain_results();
    end

    if (fail_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // receiver stalls follow a 16-bit ready pattern that is redrawn each time it runs out
  always @(posedge clk) begin
    if (pattern_pos == 0) begin
      case ($urandom_range(0, 4))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'h1111;
        3: ready_pattern = 16'h0001;
        default: ready_pattern = 16'($urandom) | 16'($urandom);
      endcase
    end
    out_tready  <= ready_pattern[pattern_pos];
    pattern_pos = (pattern_pos + 1) % 16;
  end

  initial begin
    out_tready  = 1'b0;
    pattern_pos = 0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $error("unexpected result %0h", out_tdata);
        fail_cnt++;
      end else begin
        owed_report = report_q.pop_front();
        check_field("entry_next", 32'(owed_report.next), 32'(out_tdata[7:0]));
        check_field("entry_cost", 32'(owed_report.cost), 32'(out_tdata[31:8]));
        check_field("changed", 32'(owed_report.changed), 32'(out_tdata[32]));
        check_field("round_unchanged", 32'(owed_report.round_unch), 32'(out_tdata[33]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/dvtm_pkg.sv
rtl/dvtm_ram.sv
rtl/dvtm_merge.sv
rtl/distance_vector_table_merge_top.sv
dv/distance_vector_table_merge_top_tb.sv
